/* rtl/assert_macros.svh */
// assertion macros included by the scan driver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked on clk, off while rst_n is low
`define SSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssd assertion failed");
// checked on clk, also while rst_n is low
`define SSD_ASSERT_NORST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ssd assertion failed during reset");
`else
`define SSD_ASSERT(label, prop)
`define SSD_ASSERT_NORST(label, prop)
`endif

`endif

/* rtl/ssd_pkg.sv */
// types, constants and helpers of the seven-segment scan driver
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int FuncW    = 2;
  localparam int ValueW   = 14;
  localparam int DotW     = 4;
  localparam int ReadingW = 24;
  localparam int SegW     = 8;
  localparam int EnW      = 4;
  localparam int NumW     = 14;
  localparam int QuotW    = 15;
  localparam int HalfW    = NumW / 2;
  localparam int BcdW     = 16;
  localparam int BcdDigs  = BcdW / 4;
  localparam int RecipW   = 25;
  localparam int ProdW    = ReadingW + RecipW;
  localparam int DotBit   = 7;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic CfgIdxActiveLow = 1'b0;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_VALUE   = 2'd1,
    FUNC_READING = 2'd2,
    FUNC_DOTS    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SCALE_NONE,
    SCALE_DIV10,
    SCALE_DIV100,
    SCALE_DIV1000
  } scale_t;

  // floor(x / d) == (x * Recip) >> Shift over the range each one is used in
  localparam logic [RecipW-1:0] RecipOne  = 25'd1;
  localparam logic [RecipW-1:0] Recip10   = 25'd104858;
  localparam logic [RecipW-1:0] Recip100  = 25'd1342178;
  localparam logic [RecipW-1:0] Recip1000 = 25'd17179870;
  localparam int Shift10   = 20;
  localparam int Shift100  = 27;
  localparam int Shift1000 = 34;

  localparam logic [ReadingW-1:0] RangeTen     = 24'd10000;
  localparam logic [ReadingW-1:0] RangeHundred = 24'd100000;
  localparam logic [ReadingW-1:0] RangeThous   = 24'd1000000;

  localparam logic [DotW-1:0] DotsAfter0 = 4'b0001;
  localparam logic [DotW-1:0] DotsAfter1 = 4'b0010;
  localparam logic [DotW-1:0] DotsAfter2 = 4'b0100;
  localparam logic [DotW-1:0] DotsNone   = 4'b0000;

  typedef struct packed {
    func_t           func;
    logic [DotW-1:0] dots;
  } item_ctl_t;

  // segments a..g in bits 0..6, codes above nine stay dark
  function automatic logic [SegW-2:0] seg_pattern(input logic [3:0] digit);
    logic [SegW-2:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h27;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/ssd_if.sv */
// valid/ready channel interfaces for command items and scan results
`timescale 1ns / 1ps

interface ssd_in_if import ssd_pkg::*; ();
  logic                valid;
  logic                ready;
  func_t               func;
  logic [ValueW-1:0]   value;
  logic [DotW-1:0]     dot_mask;
  logic [ReadingW-1:0] reading_milli;

  modport source (output valid, func, value, dot_mask, reading_milli, input ready);
  modport sink   (input valid, func, value, dot_mask, reading_milli, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SegW-1:0] segment_lines;
  logic [EnW-1:0]  digit_enable;

  modport source (output valid, segment_lines, digit_enable, input ready);
  modport sink   (input valid, segment_lines, digit_enable, output ready);
endinterface

/* rtl/seven_segment_scan_driver_unit.sv */
// top level of the multiplexed seven-segment scan driver
//
//  channel   dir  handshake          carries
//  in_chan   in   valid/ready        func, value, dot_mask, reading_milli
//  out_chan  out  valid/ready        segment_lines, digit_enable (one per tick)
//  cfg_*     in   apb, pready high   segments_active_low at byte address 0
//
//  one transaction per cycle while out_chan is not stalled; a tick's result passes
//  five registers after acceptance: input, 24x25 reciprocal multiply, scale and
//  clamp, first half of the bcd split, then store update or output register
//  commands update the digit and dot stores as they leave the last stage
//  rst_n is synchronous; it empties the pipe and clears stores and scan position
//  a stalled output holds a tick in the last stage and everything behind it;
//  a command in the last stage still retires and bubbles ahead of a stall close up
`timescale 1ns / 1ps
`include "assert_macros.svh"

module seven_segment_scan_driver_unit import ssd_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  ssd_in_if.sink              in_chan,
  ssd_out_if.source           out_chan,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  localparam int PosW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(DIGITS - 1);
  localparam logic [NumW-1:0] NumLimit = NumW'((DIGITS == 1) ? 9 :
                                               (DIGITS == 2) ? 99 :
                                               (DIGITS == 3) ? 999 : 9999);

  function automatic logic [BcdW-1:0] bcd_half(input logic [BcdW-1:0] bcd_in,
                                               input logic [HalfW-1:0] bits);
    logic [BcdW-1:0] acc;
    acc = bcd_in;
    for (int i = HalfW - 1; i >= 0; i--) begin
      for (int n = 0; n < BcdDigs; n++) begin
        if (acc[4*n +: 4] >= 4'd5) begin
          acc[4*n +: 4] = acc[4*n +: 4] + 4'd3;
        end
      end
      acc = {acc[BcdW-2:0], bits[i]};
    end
    return acc;
  endfunction

  // configuration
  logic active_low_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == CfgIdxActiveLow);
  assign cfg_prdata = (cfg_paddr[2] == CfgIdxActiveLow) ?
                      {{(CfgDataW-1){1'b0}}, active_low_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= 1'b1;
    end else if (cfg_wr) begin
      active_low_r <= cfg_pwdata[0];
    end
  end

  // pipeline registers
  logic                s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic                s1_valid_nxt, s2_valid_nxt, s3_valid_nxt, s4_valid_nxt;
  logic                out_valid_nxt;
  func_t               s1_func_r;
  logic [ValueW-1:0]   s1_value_r;
  logic [DotW-1:0]     s1_mask_r;
  logic [ReadingW-1:0] s1_reading_r;
  item_ctl_t           s2_ctl_r, s3_ctl_r, s4_ctl_r;
  item_ctl_t           s2_ctl_nxt;
  scale_t              s2_scale_r, s2_scale_nxt;
  logic [ProdW-1:0]    s2_prod_r, s2_prod_nxt;
  logic [NumW-1:0]     s3_num_r, s3_num_nxt;
  logic [BcdW-1:0]     s4_bcd_r, s4_bcd_nxt;
  logic [HalfW-1:0]    s4_low_r;
  logic [SegW-1:0]     out_seg_r, out_seg_nxt;
  logic [EnW-1:0]      out_en_r, out_en_nxt;

  // state
  logic [3:0]          digit_store_r [DIGITS];
  logic [3:0]          new_digit [DIGITS];
  logic [DotW-1:0]     dot_store_r;
  logic [PosW-1:0]     scan_pos_r, scan_pos_nxt;

  // flow control: each stage moves when the next one is free
  logic in_acc, out_free;
  logic s1_go, s2_go, s3_go, s4_go;
  logic s1_free, s2_free, s3_free, s4_free;
  logic s4_tick;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s4_tick  = (s4_ctl_r.func == FUNC_TICK);
  assign s4_go    = s4_valid_r && (!s4_tick || out_free);
  assign s4_free  = !s4_valid_r || s4_go;
  assign s3_go    = s3_valid_r && s4_free;
  assign s3_free  = !s3_valid_r || s3_go;
  assign s2_go    = s2_valid_r && s3_free;
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_go;

  assign in_chan.ready = s1_free;
  assign in_acc = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign s2_valid_nxt  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_r);
  assign s3_valid_nxt  = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_valid_r);
  assign s4_valid_nxt  = s3_go ? 1'b1 : (s4_go ? 1'b0 : s4_valid_r);
  assign out_valid_nxt = (s4_go && s4_tick) ? 1'b1 :
                         (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      s4_valid_r  <= s4_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage 1 -> 2: pick range and reciprocal, one multiply
  logic [ReadingW-1:0] mul_op;
  logic [RecipW-1:0]   mul_recip;

  always_comb begin
    s2_ctl_nxt.func = s1_func_r;
    s2_ctl_nxt.dots = s1_mask_r;
    s2_scale_nxt    = SCALE_NONE;
    mul_op          = {{(ReadingW-ValueW){1'b0}}, s1_value_r};
    if (s1_func_r == FUNC_READING) begin
      mul_op = s1_reading_r;
      priority if (s1_reading_r < RangeTen) begin
        s2_scale_nxt    = SCALE_NONE;
        s2_ctl_nxt.dots = DotsAfter0;
      end else if (s1_reading_r < RangeHundred) begin
        s2_scale_nxt    = SCALE_DIV10;
        s2_ctl_nxt.dots = DotsAfter1;
      end else if (s1_reading_r < RangeThous) begin
        s2_scale_nxt    = SCALE_DIV100;
        s2_ctl_nxt.dots = DotsAfter2;
      end else begin
        s2_scale_nxt    = SCALE_DIV1000;
        s2_ctl_nxt.dots = DotsNone;
      end
    end
    unique case (s2_scale_nxt)
      SCALE_NONE:    mul_recip = RecipOne;
      SCALE_DIV10:   mul_recip = Recip10;
      SCALE_DIV100:  mul_recip = Recip100;
      SCALE_DIV1000: mul_recip = Recip1000;
      default:       mul_recip = RecipOne;
    endcase
    s2_prod_nxt = mul_op * mul_recip;
  end

  // stage 2 -> 3: drop the fraction and saturate
  logic [QuotW-1:0] quot;

  always_comb begin
    unique case (s2_scale_r)
      SCALE_NONE:    quot = s2_prod_r[QuotW-1:0];
      SCALE_DIV10:   quot = s2_prod_r[Shift10 +: QuotW];
      SCALE_DIV100:  quot = s2_prod_r[Shift100 +: QuotW];
      SCALE_DIV1000: quot = s2_prod_r[Shift1000 +: QuotW];
      default:       quot = s2_prod_r[QuotW-1:0];
    endcase
    s3_num_nxt = (quot > {1'b0, NumLimit}) ? NumLimit : quot[NumW-1:0];
  end

  // stage 3 -> 4 and 4 -> store: binary to bcd in two halves
  logic [BcdW-1:0] bcd_fin;

  assign s4_bcd_nxt = bcd_half('0, s3_num_r[NumW-1:HalfW]);
  assign bcd_fin    = bcd_half(s4_bcd_r, s4_low_r);

  // digit 0 is the most significant place
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      new_digit[i] = '0;
      for (int n = 0; n < BcdDigs; n++) begin
        if (n == DIGITS - 1 - i) begin
          new_digit[i] = bcd_fin[4*n +: 4];
        end
      end
    end
  end

  // scan output for the current position
  logic [SegW-1:0] lit;
  logic            dot_lit;

  always_comb begin
    dot_lit    = 1'b0;
    out_en_nxt = '0;
    for (int n = 0; n < EnW; n++) begin
      if (int'(scan_pos_r) == n) begin
        dot_lit       = dot_store_r[n];
        out_en_nxt[n] = 1'b1;
      end
    end
    lit          = {dot_lit, seg_pattern(digit_store_r[scan_pos_r])};
    out_seg_nxt  = active_low_r ? ~lit : lit;
    scan_pos_nxt = (scan_pos_r == PosLast) ? '0 : scan_pos_r + 1'b1;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r    <= in_chan.func;
      s1_value_r   <= in_chan.value;
      s1_mask_r    <= in_chan.dot_mask;
      s1_reading_r <= in_chan.reading_milli;
    end
    if (s1_go) begin
      s2_ctl_r   <= s2_ctl_nxt;
      s2_scale_r <= s2_scale_nxt;
      s2_prod_r  <= s2_prod_nxt;
    end
    if (s2_go) begin
      s3_ctl_r <= s2_ctl_r;
      s3_num_r <= s3_num_nxt;
    end
    if (s3_go) begin
      s4_ctl_r <= s3_ctl_r;
      s4_bcd_r <= s4_bcd_nxt;
      s4_low_r <= s3_num_r[HalfW-1:0];
    end
    if (s4_go && s4_tick) begin
      out_seg_r <= out_seg_nxt;
      out_en_r  <= out_en_nxt;
    end
  end

  // display state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) begin
        digit_store_r[i] <= '0;
      end
      dot_store_r <= '0;
      scan_pos_r  <= '0;
    end else if (s4_go) begin
      unique case (s4_ctl_r.func)
        FUNC_TICK: begin
          scan_pos_r <= scan_pos_nxt;
        end
        FUNC_VALUE, FUNC_READING: begin
          for (int i = 0; i < DIGITS; i++) begin
            digit_store_r[i] <= new_digit[i];
          end
          dot_store_r <= s4_ctl_r.dots;
        end
        FUNC_DOTS: begin
          dot_store_r <= s4_ctl_r.dots;
        end
        default: begin
          dot_store_r <= dot_store_r;
        end
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.segment_lines = out_seg_r;
  assign out_chan.digit_enable  = out_en_r;

  `SSD_ASSERT(a_pos_range, scan_pos_r <= PosLast)
  `SSD_ASSERT(a_tick_reaches_out, s4_go && s4_tick |=> out_valid_r)
  `SSD_ASSERT(a_enable_onehot, out_valid_r |-> $onehot0(out_en_r))
  `SSD_ASSERT_NORST(a_reset_empties, !rst_n |=> !out_valid_r && !s1_valid_r && !s4_valid_r)

endmodule
